### design/assert_macros.svh
// Assertion helpers shared by the design files.
// CHK_HOLDS checks an expression at every clock edge outside reset.
// CHK_IMPLIES checks a same-cycle implication.
// CHK_NEXT checks an implication whose consequent must hold in the following cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_HOLDS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define CHK_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_HOLDS(lbl, clk, rstn, expr)
`define CHK_IMPLIES(lbl, clk, rstn, ante, cons)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/rarsf_pkg.sv
package rarsf_pkg;

  localparam int DATA_W           = 64;
  localparam int IDX_W            = 11;
  localparam int POS_W            = IDX_W + 1;
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam logic [IDX_W-1:0] LEN_RESET = 11'd1024;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_t;

endpackage

### design/rarsf_ram.sv
module rarsf_ram #(
  parameter int WIDTH = rarsf_pkg::DATA_W,
  parameter int DEPTH = rarsf_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/rarsf_alu.sv
module rarsf_alu (
  input  rarsf_pkg::alu_op_t             op,
  input  logic [rarsf_pkg::DATA_W-1:0]   a,
  input  logic [rarsf_pkg::DATA_W-1:0]   b,
  output logic [rarsf_pkg::DATA_W-1:0]   y
);

  localparam int DW = rarsf_pkg::DATA_W;
  localparam int IW = rarsf_pkg::IDX_W;

  logic [DW+IW-1:0] prod;

  // The multiplier operand is always an index, so only its low bits are used.
  assign prod = {{IW{1'b0}}, a} * {{DW{1'b0}}, b[IW-1:0]};

  always_comb begin
    case (op)
      rarsf_pkg::ALU_ADD: y = a + b;
      rarsf_pkg::ALU_SUB: y = a - b;
      rarsf_pkg::ALU_MUL: y = prod[DW-1:0];
      default:            y = a;
    endcase
  end

endmodule

### design/range_add_range_sum_fenwick.sv
// Throughput: one item at a time; each walk visits at most log2(length) + 1 nodes,
// and each node takes a memory read state, then one add of the shared unit per tree.
// Reset: synchronous, active low; a clearing pass then zeroes both trees, during
// which no item is accepted. The length register resets to 1024.
`include "assert_macros.svh"

module range_add_range_sum_fenwick #(
  parameter int MAX_ELEMENTS = rarsf_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [rarsf_pkg::IDX_W-1:0]          in_left_index,
  input  logic [rarsf_pkg::IDX_W-1:0]          in_right_index,
  input  logic signed [rarsf_pkg::DATA_W-1:0]  in_add_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rarsf_pkg::DATA_W-1:0]         out_range_sum,
  output logic                                 out_bad_range,
  input  logic                                 cfg_wr_en,
  input  logic [rarsf_pkg::IDX_W-1:0]          cfg_wr_data
);

  localparam int DW  = rarsf_pkg::DATA_W;
  localparam int IW  = rarsf_pkg::IDX_W;
  localparam int PW  = rarsf_pkg::POS_W;
  localparam int AW  = $clog2(MAX_ELEMENTS);
  // The index fields are 11 bits wide, so no walk can reach beyond this.
  localparam int CAP = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;

  // One-hot sequencer states.
  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_APREP = 16'h0004,
    S_WRD   = 16'h0008,
    S_WUD   = 16'h0010,
    S_WUW   = 16'h0020,
    S_NEG_D = 16'h0040,
    S_MUL_W = 16'h0080,
    S_NEG_W = 16'h0100,
    S_QRD   = 16'h0200,
    S_QAD   = 16'h0400,
    S_QAW   = 16'h0800,
    S_QMUL  = 16'h1000,
    S_QSUB  = 16'h2000,
    S_QFIN  = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  // Control registers.
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [IW-1:0]   len_r, len_nxt;
  logic            second_r, second_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Payload and working registers.
  logic [DW-1:0]   v_r, v_nxt;
  logic [IW-1:0]   l_r, l_nxt;
  logic [IW-1:0]   r_r, r_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [IW-1:0]   ppos_r, ppos_nxt;
  logic [DW-1:0]   wk_d_r, wk_d_nxt;
  logic [DW-1:0]   wk_w_r, wk_w_nxt;
  logic [DW-1:0]   tmp_r, tmp_nxt;
  logic [DW-1:0]   res_r, res_nxt;
  logic            bad_r, bad_nxt;
  logic [DW-1:0]   out_sum_r, out_sum_nxt;
  logic            out_bad_r, out_bad_nxt;

  // Datapath signals.
  logic [IW-1:0]         eff_len;
  logic                  in_bad;
  logic                  walk_ok;
  logic [PW-1:0]         lowbit;
  logic [AW-1:0]         walk_addr;
  logic [AW-1:0]         wr_addr;
  logic                  we_d, we_w;
  logic [DW-1:0]         wr_data;
  logic [DW-1:0]         q_d, q_w;
  rarsf_pkg::alu_op_t    alu_op;
  logic [DW-1:0]         alu_a, alu_b, alu_y;

  // The length in use never exceeds the tree size.
  assign eff_len = (len_r > IW'(CAP)) ? IW'(CAP) : len_r;

  assign in_bad = (in_left_index == '0) || (in_left_index > in_right_index)
               || (in_right_index > eff_len);

  // A tree walk visits a node only while its position lies inside 1..length.
  assign walk_ok   = (pos_r != '0) && (pos_r <= {1'b0, eff_len});
  assign lowbit    = pos_r & (~pos_r + PW'(1));
  assign walk_addr = walk_ok ? AW'(pos_r - PW'(1)) : '0;

  // The clearing pass and the walks share the single write port of each tree.
  assign wr_addr = (state_r == S_CLEAR) ? clr_r : walk_addr;
  assign wr_data = (state_r == S_CLEAR) ? '0 : alu_y;
  assign we_d    = (state_r == S_CLEAR) || (state_r == S_WUD);
  assign we_w    = (state_r == S_CLEAR) || (state_r == S_WUW);

  rarsf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ELEMENTS)
  ) u_diff_ram (
    .clk     (clk),
    .wr_en   (we_d),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (walk_addr),
    .rd_data (q_d)
  );

  rarsf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ELEMENTS)
  ) u_wgt_ram (
    .clk     (clk),
    .wr_en   (we_w),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (walk_addr),
    .rd_data (q_w)
  );

  rarsf_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Operand selection for the shared unit. Every add, subtract and multiply of an
  // item's values goes through it, one operation per cycle; the index steps do not.
  always_comb begin
    alu_op = rarsf_pkg::ALU_ADD;
    alu_a  = q_d;
    alu_b  = wk_d_r;
    case (state_r)
      S_APREP: begin
        alu_op = rarsf_pkg::ALU_MUL;
        alu_a  = v_r;
        alu_b  = DW'(l_r - IW'(1));
      end
      S_WUD: begin
        alu_a = q_d;
        alu_b = wk_d_r;
      end
      S_WUW: begin
        alu_a = q_w;
        alu_b = wk_w_r;
      end
      S_NEG_D: begin
        alu_op = rarsf_pkg::ALU_SUB;
        alu_a  = '0;
        alu_b  = v_r;
      end
      S_MUL_W: begin
        alu_op = rarsf_pkg::ALU_MUL;
        alu_a  = v_r;
        alu_b  = DW'(r_r);
      end
      S_NEG_W: begin
        alu_op = rarsf_pkg::ALU_SUB;
        alu_a  = '0;
        alu_b  = wk_w_r;
      end
      S_QAD: begin
        alu_a = wk_d_r;
        alu_b = q_d;
      end
      S_QAW: begin
        alu_a = wk_w_r;
        alu_b = q_w;
      end
      S_QMUL: begin
        alu_op = rarsf_pkg::ALU_MUL;
        alu_a  = wk_d_r;
        alu_b  = DW'(ppos_r);
      end
      S_QSUB: begin
        alu_op = rarsf_pkg::ALU_SUB;
        alu_a  = tmp_r;
        alu_b  = wk_w_r;
      end
      S_QFIN: begin
        alu_op = rarsf_pkg::ALU_SUB;
        alu_a  = res_r;
        alu_b  = tmp_r;
      end
      default: begin
        alu_op = rarsf_pkg::ALU_ADD;
      end
    endcase
  end

  // Sequencer. A range add walks both trees upwards from the left end with the
  // value and value * (left - 1), then from one past the right end with -value
  // and -(value * right). A query forms the prefix sum p * S_d(p) - S_w(p) at
  // the right end, then at one before the left end, and returns the difference.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    len_nxt       = len_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r;
    v_nxt         = v_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    pos_nxt       = pos_r;
    ppos_nxt      = ppos_r;
    wk_d_nxt      = wk_d_r;
    wk_w_nxt      = wk_w_r;
    tmp_nxt       = tmp_r;
    res_nxt       = res_r;
    bad_nxt       = bad_r;
    out_sum_nxt   = out_sum_r;
    out_bad_nxt   = out_bad_r;

    if (cfg_wr_en) begin
      len_nxt = cfg_wr_data;
    end

    // The output register empties as soon as its item is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_ELEMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          v_nxt      = $unsigned(in_add_value);
          l_nxt      = in_left_index;
          r_nxt      = in_right_index;
          second_nxt = 1'b0;
          if (!in_kind) begin
            // An add over a bad range is dropped without a trace.
            if (!in_bad) begin
              pos_nxt   = PW'(in_left_index);
              state_nxt = S_APREP;
            end
          end else if (in_bad) begin
            res_nxt   = '0;
            bad_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            pos_nxt   = PW'(in_right_index);
            ppos_nxt  = in_right_index;
            wk_d_nxt  = '0;
            wk_w_nxt  = '0;
            bad_nxt   = 1'b0;
            state_nxt = S_QRD;
          end
        end
      end
      S_APREP: begin
        wk_d_nxt  = v_r;
        wk_w_nxt  = alu_y;
        state_nxt = S_WRD;
      end
      S_WRD: begin
        if (walk_ok) begin
          state_nxt = S_WUD;
        end else if (second_r) begin
          state_nxt = S_IDLE;
        end else begin
          second_nxt = 1'b1;
          state_nxt  = S_NEG_D;
        end
      end
      S_WUD: begin
        state_nxt = S_WUW;
      end
      S_WUW: begin
        pos_nxt   = pos_r + lowbit;
        state_nxt = S_WRD;
      end
      S_NEG_D: begin
        wk_d_nxt  = alu_y;
        state_nxt = S_MUL_W;
      end
      S_MUL_W: begin
        wk_w_nxt  = alu_y;
        state_nxt = S_NEG_W;
      end
      S_NEG_W: begin
        wk_w_nxt  = alu_y;
        pos_nxt   = PW'(r_r) + PW'(1);
        state_nxt = S_WRD;
      end
      S_QRD: begin
        state_nxt = walk_ok ? S_QAD : S_QMUL;
      end
      S_QAD: begin
        wk_d_nxt  = alu_y;
        state_nxt = S_QAW;
      end
      S_QAW: begin
        wk_w_nxt  = alu_y;
        pos_nxt   = pos_r - lowbit;
        state_nxt = S_QRD;
      end
      S_QMUL: begin
        tmp_nxt   = alu_y;
        state_nxt = S_QSUB;
      end
      S_QSUB: begin
        if (!second_r) begin
          res_nxt    = alu_y;
          second_nxt = 1'b1;
          pos_nxt    = PW'(l_r - IW'(1));
          ppos_nxt   = l_r - IW'(1);
          wk_d_nxt   = '0;
          wk_w_nxt   = '0;
          state_nxt  = S_QRD;
        end else begin
          tmp_nxt   = alu_y;
          state_nxt = S_QFIN;
        end
      end
      S_QFIN: begin
        res_nxt   = alu_y;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Wait here only while the previous result item is still unclaimed.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = res_r;
          out_bad_nxt   = bad_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      len_r       <= rarsf_pkg::LEN_RESET;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      len_r       <= len_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    pos_r     <= pos_nxt;
    ppos_r    <= ppos_nxt;
    wk_d_r    <= wk_d_nxt;
    wk_w_r    <= wk_w_nxt;
    tmp_r     <= tmp_nxt;
    res_r     <= res_nxt;
    bad_r     <= bad_nxt;
    out_sum_r <= out_sum_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;
  assign out_bad_range = out_bad_r;

  // A result item flagged as a bad range always carries a zero sum.
  `CHK_IMPLIES(a_bad_zero, clk, rst_n, out_valid_r && out_bad_r, out_sum_r == '0)
  // Walk writes to the trees only ever land on nodes inside the length in use.
  `CHK_IMPLIES(a_wr_bounds, clk, rst_n, state_r == S_WUD || state_r == S_WUW, walk_ok)
  // An accepted query always keeps the block busy in the following cycle.
  `CHK_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && in_kind, !in_ready)
  // Nothing is accepted or delivered while the trees are being cleared.
  `CHK_IMPLIES(a_clear_quiet, clk, rst_n, state_r == S_CLEAR, !in_ready && !out_valid_r)

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // The two kinds of item the block accepts.
  typedef enum bit {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_kind_t;

  // Selects one of the two trees in the local copy of the store.
  localparam int DIFF_TREE   = 0;
  localparam int WEIGHT_TREE = 1;

  // The widest add walks two paths of up to eleven nodes, each node touching
  // both trees; SETTLE_CYCLES of quiet cover an add whose effect cannot be seen
  // at the outputs.
  localparam int SETTLE_CYCLES = 160;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 170;

  localparam bit [63:0] VAL_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] VAL_MIN  = 64'h8000_0000_0000_0000;
  localparam bit [63:0] VAL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // One expected result item: the range sum and the bad range flag.
  typedef struct packed {
    bit [63:0] sum;
    bit        bad;
  } span_result_t;

  // One row of the directed stimulus. Where fixed_check is set, the expected
  // result is the one typed into the row and not the one the predictor gives.
  typedef struct packed {
    op_kind_t    kind;
    bit [10:0]   left;
    bit [10:0]   right;
    bit [63:0]   value;
    bit          fixed_check;
    bit [63:0]   want_sum;
    bit          want_bad;
  } stim_row_t;

  // Directed items. The checks typed in are the empty store after reset, the
  // effect of the ignored adds, and the bad range cases: left index zero, left
  // above right, and right beyond the length in use. The adds use the extreme
  // values over the whole array, the last element and a middle span, a small
  // value on the first element, and the queries that follow go to the predictor.
  localparam int DIRECTED_ROWS = 23;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_QUERY, 11'd1,    11'd1024, 64'd0,    1'b1, 64'd0, 1'b0},
    '{OP_QUERY, 11'd1,    11'd1,    64'd0,    1'b1, 64'd0, 1'b0},
    '{OP_QUERY, 11'd0,    11'd5,    VAL_ONES, 1'b1, 64'd0, 1'b1},
    '{OP_QUERY, 11'd9,    11'd3,    64'd0,    1'b1, 64'd0, 1'b1},
    '{OP_QUERY, 11'd1,    11'd1025, 64'd0,    1'b1, 64'd0, 1'b1},
    '{OP_QUERY, 11'd2047, 11'd2047, 64'd0,    1'b1, 64'd0, 1'b1},
    '{OP_QUERY, 11'd1025, 11'd1024, 64'd0,    1'b1, 64'd0, 1'b1},
    '{OP_ADD,   11'd0,    11'd4,    64'd123,  1'b0, 64'd0, 1'b0},
    '{OP_ADD,   11'd7,    11'd2,    VAL_MAX,  1'b0, 64'd0, 1'b0},
    '{OP_ADD,   11'd1,    11'd2047, VAL_MIN,  1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd1,    11'd1024, 64'd0,    1'b1, 64'd0, 1'b0},
    '{OP_ADD,   11'd1,    11'd1,    64'd5,    1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd1,    11'd1,    64'd0,    1'b0, 64'd0, 1'b0},
    '{OP_ADD,   11'd1,    11'd1024, VAL_MAX,  1'b0, 64'd0, 1'b0},
    '{OP_ADD,   11'd1024, 11'd1024, VAL_MIN,  1'b0, 64'd0, 1'b0},
    '{OP_ADD,   11'd512,  11'd700,  VAL_ONES, 1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd1,    11'd1024, 64'd0,    1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd1024, 11'd1024, 64'd0,    1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd512,  11'd512,  64'd0,    1'b0, 64'd0, 1'b0},
    '{OP_ADD,   11'd1,    11'd1024, 64'd0,    1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd2,    11'd1023, 64'd0,    1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd700,  11'd701,  64'd0,    1'b0, 64'd0, 1'b0},
    '{OP_QUERY, 11'd1,    11'd1024, VAL_ONES, 1'b0, 64'd0, 1'b0}
  };

  // The length settings that the random phases run under, in order. They
  // include the smallest lengths, zero, which makes every range bad, and the
  // largest value the register takes, which acts as the full array.
  localparam int PHASES = 8;
  localparam bit [10:0] LENGTH_PLAN [PHASES] = '{
    11'd1, 11'd2, 11'd0, 11'd2047, 11'd37, 11'd700, 11'd513, 11'd1024
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [10:0] in_left_index;
  logic [10:0] in_right_index;
  logic signed [63:0] in_add_value;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_range_sum;
  logic        out_bad_range;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;

  range_add_range_sum_fenwick #(
    .MAX_ELEMENTS(rarsf_pkg::MAX_ELEMENTS_DEF)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_left_index (in_left_index),
    .in_right_index(in_right_index),
    .in_add_value  (in_add_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_range_sum (out_range_sum),
    .out_bad_range (out_bad_range),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Local copy of the two trees and of the length register. Nodes beyond the
  // current length are kept, as in the block, and come back into use when the
  // length grows again.
  bit [63:0]   bit_tree [2][1:rarsf_pkg::MAX_ELEMENTS_DEF];
  int unsigned cur_length;

  // Results still owed by the block, oldest first.
  span_result_t pending_sums [$];

  int unsigned error_count;
  int unsigned items_accepted;
  int unsigned adds_applied;
  int unsigned bad_ranges;
  int unsigned results_checked;
  int unsigned lengths_written;
  int unsigned burst_left;
  int unsigned ready_left;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // The bound of every tree walk: the length register, held at the size
  // of the array when it is set above it.
  function automatic int unsigned walk_bound();
    return (cur_length > rarsf_pkg::MAX_ELEMENTS_DEF) ? rarsf_pkg::MAX_ELEMENTS_DEF
                                                       : cur_length;
  endfunction

  function automatic bit range_is_bad(input bit [10:0] left, input bit [10:0] right);
    return (left == '0) || (left > right) || (32'(right) > walk_bound());
  endfunction

  // Adds delta at pos and at every node that covers it, stopping at the bound.
  function automatic void node_add(input int sel, input int unsigned pos,
                                   input bit [63:0] delta);
    int unsigned n;
    n = walk_bound();
    while (pos != 0 && pos <= n) begin
      bit_tree[sel][pos] += delta;
      pos += pos & (~pos + 1);
    end
  endfunction

  // Sum of the tree nodes that make up the prefix up to pos.
  function automatic bit [63:0] node_prefix(input int sel, input int unsigned pos);
    bit [63:0]   acc;
    int unsigned n;
    acc = '0;
    n   = walk_bound();
    if (pos > n) pos = n;
    while (pos != 0) begin
      acc += bit_tree[sel][pos];
      pos -= pos & (~pos + 1);
    end
    return acc;
  endfunction

  // Sum of elements 1..pos: pos times the prefix of the differences, less
  // the prefix of the weighted differences, all modulo 2^64.
  function automatic bit [63:0] element_prefix(input int unsigned pos);
    bit [63:0] wide_pos;
    wide_pos = 64'(pos);
    return wide_pos * node_prefix(DIFF_TREE, pos) - node_prefix(WEIGHT_TREE, pos);
  endfunction

  // Applies one item to the local store and gives the result it causes.
  function automatic void predict_span(input op_kind_t kind, input bit [10:0] left,
                                       input bit [10:0] right, input bit [63:0] value,
                                       output bit has_result, output span_result_t res);
    bit        bad;
    bit [63:0] left_less_one;
    bit [63:0] right_wide;
    bad           = range_is_bad(left, right);
    left_less_one = 64'(left) - 64'd1;
    right_wide    = 64'(right);
    has_result    = (kind == OP_QUERY);
    res           = '0;
    if (kind == OP_ADD) begin
      if (!bad) begin
        node_add(DIFF_TREE, 32'(left), value);
        node_add(DIFF_TREE, 32'(right) + 32'd1, -value);
        node_add(WEIGHT_TREE, 32'(left), value * left_less_one);
        node_add(WEIGHT_TREE, 32'(right) + 32'd1, -(value * right_wide));
      end
    end else if (bad) begin
      res.bad = 1'b1;
    end else begin
      res.sum = element_prefix(32'(right)) - element_prefix(32'(left) - 32'd1);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Presents one item and holds it until the block takes it. The expected
  // result is worked out at the edge of acceptance, so that it follows the
  // same order of items as the block.
  task automatic drive_item(input op_kind_t kind, input bit [10:0] left,
                            input bit [10:0] right, input bit [63:0] value,
                            input bit fixed_check, input span_result_t fixed_result);
    bit           has_result;
    span_result_t predicted;
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_left_index  <= left;
    in_right_index <= right;
    in_add_value   <= value;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_accepted++;
    if (range_is_bad(left, right)) bad_ranges++;
    else if (kind == OP_ADD) adds_applied++;
    predict_span(kind, left, right, value, has_result, predicted);
    if (has_result) pending_sums.push_back(fixed_check ? fixed_result : predicted);
  endtask

  // Bursts of back-to-back items with random gaps between them. Long bursts
  // with no gap give stretches where the block is never left waiting.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_sums.size() != 0);
  endtask

  // Changes the length register with the block idle. Adds give no result, so
  // after the last result the block is given time to finish any add still
  // under way before the write.
  task automatic write_length(input bit [10:0] len);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cur_length = 32'(len);
    lengths_written++;
  endtask

  // Random items under the current length. Unless the length is zero, most
  // ranges are well formed, with a bias to prefix, suffix and short spans; the
  // rest are bad ranges of every sort. Adds with a bad range are ignored by the
  // block, so they do not count toward the quota.
  task automatic run_phase(input int unsigned quota);
    int unsigned counted;
    int unsigned hold_at;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int          small_val;
    bit          held;
    op_kind_t    kind;
    bit [63:0]   value;
    counted = 0;
    held    = 1'b0;
    hold_at = $urandom_range(quota / 4, 3 * quota / 4);
    while (counted < quota) begin
      n    = walk_bound();
      kind = ($urandom_range(0, 99) < 45) ? OP_ADD : OP_QUERY;
      if (n == 0 || $urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 3))
          0: begin
            lo = 0;
            hi = $urandom_range(0, 2047);
          end
          1: begin
            lo = $urandom_range(1, 2047);
            hi = $urandom_range(0, lo - 1);
          end
          2: begin
            hi = $urandom_range(n + 1, 2047);
            lo = $urandom_range(0, hi);
          end
          default: begin
            lo = $urandom_range(0, 2047);
            hi = $urandom_range(0, 2047);
          end
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            lo = 1;
            hi = $urandom_range(1, n);
          end
          1: begin
            lo = $urandom_range(1, n);
            hi = n;
          end
          2: begin
            lo = $urandom_range(1, n);
            hi = lo + $urandom_range(0, 7);
            if (hi > n) hi = n;
          end
          default: begin
            lo = $urandom_range(1, n);
            hi = $urandom_range(lo, n);
          end
        endcase
      end
      case ($urandom_range(0, 5))
        0: begin
          small_val = int'($urandom_range(0, 200)) - 100;
          value     = 64'(small_val);
        end
        1: begin
          case ($urandom_range(0, 3))
            0:       value = VAL_MAX;
            1:       value = VAL_MIN;
            2:       value = VAL_ONES;
            default: value = '0;
          endcase
        end
        default: value = {$urandom, $urandom};
      endcase
      if (!(kind == OP_ADD && range_is_bad(11'(lo), 11'(hi)))) counted++;
      drive_item(kind, 11'(lo), 11'(hi), value, 1'b0, '0);
      if (!held && counted >= hold_at) begin
        held = 1'b1;
        hold_until_drained();
      end else begin
        pace_sender();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: checks each result and stalls on a pattern of its own,
  // runs of ready broken by stalls of random length, some runs unbroken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    span_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_checked++;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result with none expected: sum %h bad %b",
                                  out_range_sum, out_bad_range));
      end else begin
        want = pending_sums.pop_front();
        if (out_range_sum !== want.sum)
          report_mismatch($sformatf("result %0d range_sum %h, expected %h",
                                    results_checked, out_range_sum, want.sum));
        if (out_bad_range !== want.bad)
          report_mismatch($sformatf("result %0d bad_range %b, expected %b",
                                    results_checked, out_bad_range, want.bad));
      end
    end
    if (ready_left != 0) begin
      out_ready <= 1'b1;
      ready_left--;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready  <= 1'b1;
      ready_left = $urandom_range(1, 24);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_sequence
    stim_row_t   row;
    int unsigned waited;
    error_count     = 0;
    items_accepted  = 0;
    adds_applied    = 0;
    bad_ranges      = 0;
    results_checked = 0;
    lengths_written = 0;
    burst_left      = 0;
    ready_left      = 0;
    stall_left      = 0;
    cur_length      = 32'(rarsf_pkg::LEN_RESET);

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= OP_ADD;
    in_left_index  <= '0;
    in_right_index <= '0;
    in_add_value   <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= rarsf_pkg::LEN_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears both trees after reset and takes no item meanwhile.
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);

    // Directed part, at the reset length of the whole array.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      drive_item(row.kind, row.left, row.right, row.value, row.fixed_check,
                 {row.want_sum, row.want_bad});
      pace_sender();
    end

    // Random part, one phase for each length setting. The trees are not
    // cleared between phases, so shrinking and regrowing the length leaves
    // stale nodes that later sums must still account for.
    for (int p = 0; p < PHASES; p++) begin
      write_length(LENGTH_PLAN[p]);
      run_phase(PHASE_ITEMS);
    end

    // Wait for the last results, then give a trailing add time to complete.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_sums.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_sums.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", pending_sums.size()));

    $display("testbench: %0d items taken, %0d range adds applied, %0d bad ranges",
             items_accepted, adds_applied, bad_ranges);
    $display("testbench: %0d sums checked over %0d length settings from 0 to 2047",
             results_checked, lengths_written);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Guard against a block that stops answering.
  initial begin
    #2_500_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### range_add_range_sum_fenwick.f
+incdir+design
design/rarsf_pkg.sv
design/rarsf_ram.sv
design/rarsf_alu.sv
design/range_add_range_sum_fenwick.sv
sim/testbench.sv
